### src/carule_pkg.sv
// ----------------------------------------------------------------------------
// Cellular automaton rule step: shared types and constants
// Configuration register indexes, rule word layout and inter-module structs.
// ----------------------------------------------------------------------------
package carule_pkg;

  localparam int COORD_W  = 8;
  localparam int SYM_W    = 8;
  localparam int RNUM_W   = 3;
  localparam int RULE_W   = 54;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 54;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_FIRST = 3'd3;

  // Rule word layout.
  localparam int TARGET_LSB = 0;
  localparam int COND1_LSB  = 8;
  localparam int JOIN_LSB   = 26;
  localparam int COND2_LSB  = 28;
  localparam int RESULT_LSB = 46;

  // Offsets inside one condition field.
  localparam int C_LOGIC_OFS = 0;
  localparam int C_N_OFS     = 2;
  localparam int C_SYM_OFS   = 6;
  localparam int C_DIST_OFS  = 14;

  // Condition tests.
  localparam logic [1:0] LOGIC_AT_LEAST = 2'd0;
  localparam logic [1:0] LOGIC_AT_MOST  = 2'd1;
  localparam logic [1:0] LOGIC_NONE     = 2'd2;
  localparam logic [1:0] LOGIC_EXACT    = 2'd3;

  // Condition joiners.
  localparam logic [1:0] JOIN_SINGLE = 2'd0;
  localparam logic [1:0] JOIN_AND    = 2'd1;
  localparam logic [1:0] JOIN_OR     = 2'd2;
  localparam logic [1:0] JOIN_NEVER  = 2'd3;

  typedef logic [RULE_W-1:0] rule_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_WALK,
    S_LAST,
    S_DONE,
    S_OUT
  } state_e;

  // Control from the sequencer to the counter bank.
  typedef struct packed {
    logic               clear;
    logic               hit;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] ctr_row;
    logic [COORD_W-1:0] ctr_col;
  } cnt_ctrl_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [RNUM_W-1:0] num;
  } rule_res_t;

endpackage

### src/carule_grid_mem.sv
// ----------------------------------------------------------------------------
// Cellular automaton grid store
// Single-port synchronous memory of cell symbols with a registered read port.
// ----------------------------------------------------------------------------
module carule_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [carule_pkg::SYM_W-1:0] wdata_i,
  output logic [carule_pkg::SYM_W-1:0] rdata_o
);

  logic [carule_pkg::SYM_W-1:0] mem_q [DEPTH];
  logic [carule_pkg::SYM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/carule_cond_count.sv
// ----------------------------------------------------------------------------
// Cellular automaton condition counters
// Counts matching neighbors for every rule condition during one window walk
// and picks the first rule that fires.
// ----------------------------------------------------------------------------
module carule_cond_count #(
  parameter int NUM_RULES  = 5,
  parameter int MAX_RADIUS = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  carule_pkg::cnt_ctrl_t          ctrl_i,
  input  logic [carule_pkg::SYM_W-1:0]   rdata_i,
  input  logic [carule_pkg::SYM_W-1:0]   cur_i,
  input  logic [carule_pkg::RNUM_W-1:0]  nr_i,
  input  carule_pkg::rule_word_t         rules_i [NUM_RULES],
  output carule_pkg::rule_res_t          res_o
);

  localparam int NCOND   = 2 * NUM_RULES;
  localparam int WIN     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2(WIN);

  logic [CNT_W-1:0] cnt_q [NCOND];
  logic [CNT_W-1:0] cnt_d [NCOND];
  logic [carule_pkg::COORD_W-1:0] dr, dc;
  logic             is_ctr;

  function automatic logic [17:0] cond_field(carule_pkg::rule_word_t w, int q);
    return (q == 0) ? w[carule_pkg::COND1_LSB +: 18] : w[carule_pkg::COND2_LSB +: 18];
  endfunction

  function automatic logic [3:0] clamp_dist(logic [3:0] d);
    return (32'(d) > MAX_RADIUS) ? 4'(MAX_RADIUS) : d;
  endfunction

  always_comb begin
    dr = (ctrl_i.row > ctrl_i.ctr_row) ? ctrl_i.row - ctrl_i.ctr_row
                                       : ctrl_i.ctr_row - ctrl_i.row;
    dc = (ctrl_i.col > ctrl_i.ctr_col) ? ctrl_i.col - ctrl_i.ctr_col
                                       : ctrl_i.ctr_col - ctrl_i.col;
    is_ctr = (ctrl_i.row == ctrl_i.ctr_row) && (ctrl_i.col == ctrl_i.ctr_col);
    for (int k = 0; k < NCOND; k++) begin
      logic [17:0] f;
      logic [3:0]  d;
      f = cond_field(rules_i[k/2], k % 2);
      d = clamp_dist(f[carule_pkg::C_DIST_OFS +: 4]);
      cnt_d[k] = cnt_q[k];
      if (ctrl_i.clear) begin
        cnt_d[k] = '0;
      end else if (ctrl_i.hit && !is_ctr
                   && (rdata_i == f[carule_pkg::C_SYM_OFS +: 8])
                   && (dr <= carule_pkg::COORD_W'(d))
                   && (dc <= carule_pkg::COORD_W'(d))) begin
        cnt_d[k] = cnt_q[k] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NCOND; k++) cnt_q[k] <= '0;
    end else begin
      for (int k = 0; k < NCOND; k++) cnt_q[k] <= cnt_d[k];
    end
  end

  function automatic logic pass(logic [17:0] f, logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    logic             p;
    n = CNT_W'(f[carule_pkg::C_N_OFS +: 4]);
    case (f[carule_pkg::C_LOGIC_OFS +: 2])
      carule_pkg::LOGIC_AT_LEAST: p = (cnt >= n);
      carule_pkg::LOGIC_AT_MOST:  p = (cnt <= n);
      carule_pkg::LOGIC_NONE:     p = (cnt == '0);
      default:                    p = (cnt == n);
    endcase
    return p;
  endfunction

  // Scan from the highest rule down so that the lowest enabled rule wins.
  always_comb begin
    res_o.sym = cur_i;
    res_o.num = '0;
    for (int k = NUM_RULES - 1; k >= 0; k--) begin
      logic p1, p2, fire;
      p1 = pass(cond_field(rules_i[k], 0), cnt_q[2*k]);
      p2 = pass(cond_field(rules_i[k], 1), cnt_q[2*k+1]);
      case (rules_i[k][carule_pkg::JOIN_LSB +: 2])
        carule_pkg::JOIN_SINGLE: fire = p1;
        carule_pkg::JOIN_AND:    fire = p1 && p2;
        carule_pkg::JOIN_OR:     fire = p1 || p2;
        default:                 fire = 1'b0;
      endcase
      if ((32'(nr_i) > k) && (rules_i[k][carule_pkg::TARGET_LSB +: 8] == cur_i) && fire) begin
        res_o.sym = rules_i[k][carule_pkg::RESULT_LSB +: 8];
        res_o.num = carule_pkg::RNUM_W'(k + 1);
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (cnt_q[0] == '0) && (cnt_q[NCOND-1] == '0))
    else $error("counters not cleared");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[0]) < WIN)
    else $error("counter beyond window size");
  a_rule_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num <= nr_i))
    else $error("disabled rule fired");
`endif

endmodule

### src/cellular_automaton_rule_step.sv
// ----------------------------------------------------------------------------
// Cellular automaton rule step
// Stores a grid of cell symbols and evaluates neighborhood rules on a cell.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one request word:
// req_type 0 stores cell_symbol at (row, col) and answers the symbol with
// rule 0; req_type 1 evaluates the cell at (row, col). The output channel
// (out_valid_o/out_ready_i) returns one word per request: new_symbol and
// rule_number. The user sends configuration words on cfg_valid_i/cfg_ready_o
// only while the block is idle; no logic checks it. cfg_ready_o is always high.
// Operation: a store goes through S_OUT to the output register. An evaluate reads
// the center cell, then walks the clipped window of radius MAX_RADIUS with
// one grid memory read per cycle, counting for all rule conditions at once,
// up to a full 19 by 19 window; the single memory read port sets that rate.
// One request is worked on at a time. Reset clears the configuration to 64
// rows, 64 columns and no rules; the grid contents are undefined until
// written. When the receiver stalls, the result waits in the output register
// and the next request is taken; its result holds until the register frees.
// ----------------------------------------------------------------------------
module cellular_automaton_rule_step #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int NUM_RULES  = 5,
  parameter int MAX_RADIUS = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [carule_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [carule_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [5:0]                         row_i,
  input  logic [5:0]                         col_i,
  input  logic [7:0]                         cell_symbol_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         new_symbol_o,
  output logic [2:0]                         rule_number_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = carule_pkg::COORD_W;

  // Configuration registers.
  logic [6:0] rows_q, cols_q;
  logic [2:0] rcnt_q;
  carule_pkg::rule_word_t rules_q [NUM_RULES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd64;
      cols_q <= 7'd64;
      rcnt_q <= '0;
      for (int k = 0; k < NUM_RULES; k++) rules_q[k] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        carule_pkg::CFG_GRID_ROWS:  rows_q <= cfg_data_i[6:0];
        carule_pkg::CFG_GRID_COLS:  cols_q <= cfg_data_i[6:0];
        carule_pkg::CFG_RULE_COUNT: rcnt_q <= cfg_data_i[2:0];
        default: begin
          for (int k = 0; k < NUM_RULES; k++) begin
            if (32'(cfg_index_i) == 32'(carule_pkg::CFG_RULE_FIRST) + k) begin
              rules_q[k] <= cfg_data_i;
            end
          end
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [6:0] rows_eff, cols_eff;
  logic [2:0] nr;
  assign rows_eff = (32'(rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_q;
  assign cols_eff = (32'(cols_q) > MAX_COLS) ? 7'(MAX_COLS) : cols_q;
  assign nr       = (32'(rcnt_q) > NUM_RULES) ? 3'(NUM_RULES) : rcnt_q;

  // Sequencer state.
  carule_pkg::state_e state_q, state_d;
  logic [CW-1:0] r_q, c_q, r0_q, r1_q, c0_q, c1_q, i_q, j_q;
  logic [CW-1:0] r_d, c_d, r0_d, r1_d, c0_d, c1_d, i_d, j_d;
  logic [CW-1:0] ti_q, tj_q;
  logic          hit_q, hit_d;
  logic [7:0]    cur_q, cur_d;
  carule_pkg::rule_res_t res_q, res_d, fire_res;
  logic          out_valid_q, out_valid_d;
  carule_pkg::rule_res_t out_q, out_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  carule_pkg::cnt_ctrl_t cctrl;

  logic          accept, out_free, in_grid;
  logic [CW-1:0] row8, col8, rad, rlast, clast;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_grid  = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);
  assign row8     = CW'(row_i);
  assign col8     = CW'(col_i);
  assign rad      = CW'(MAX_RADIUS);
  assign rlast    = CW'(rows_eff) - CW'(1);
  assign clast    = CW'(cols_eff) - CW'(1);

  always_comb begin
    state_d     = state_q;
    r_d = r_q;  c_d = c_q;  r0_d = r0_q;  r1_d = r1_q;
    c0_d = c0_q;  c1_d = c1_q;  i_d = i_q;  j_d = j_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    hit_d       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = AW'(32'(row_i) * MAX_COLS + 32'(col_i));
    in_ready_o  = 1'b0;
    cctrl.clear   = 1'b0;
    cctrl.hit     = hit_q;
    cctrl.row     = ti_q;
    cctrl.col     = tj_q;
    cctrl.ctr_row = r_q;
    cctrl.ctr_col = c_q;

    case (state_q)
      carule_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          r_d  = row8;
          c_d  = col8;
          r0_d = (row8 > rad) ? row8 - rad : '0;
          c0_d = (col8 > rad) ? col8 - rad : '0;
          r1_d = (row8 + rad > rlast) ? rlast : row8 + rad;
          c1_d = (col8 + rad > clast) ? clast : col8 + rad;
          if (!req_type_i) begin
            mem_we  = in_grid;
            res_d.sym = cell_symbol_i;
            res_d.num = '0;
            state_d = carule_pkg::S_OUT;
          end else if (!in_grid) begin
            res_d   = '0;
            state_d = carule_pkg::S_OUT;
          end else begin
            mem_re  = 1'b1;
            state_d = carule_pkg::S_CUR;
          end
        end
      end
      carule_pkg::S_CUR: begin
        cur_d = mem_rdata;
        if ((r_q >= CW'(rows_eff)) || (c_q >= CW'(cols_eff))) begin
          res_d.sym = mem_rdata;
          res_d.num = '0;
          state_d   = carule_pkg::S_OUT;
        end else begin
          cctrl.clear = 1'b1;
          i_d     = r0_q;
          j_d     = c0_q;
          state_d = carule_pkg::S_WALK;
        end
      end
      carule_pkg::S_WALK: begin
        mem_re   = 1'b1;
        mem_addr = AW'(32'(i_q) * MAX_COLS + 32'(j_q));
        hit_d    = 1'b1;
        if (j_q == c1_q) begin
          j_d = c0_q;
          i_d = i_q + CW'(1);
          if (i_q == r1_q) state_d = carule_pkg::S_LAST;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      carule_pkg::S_LAST: begin
        // The last window read is counted in this cycle.
        state_d = carule_pkg::S_DONE;
      end
      carule_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = fire_res;
          state_d     = carule_pkg::S_IDLE;
        end
      end
      carule_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = carule_pkg::S_IDLE;
        end
      end
      default: state_d = carule_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= carule_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;  c_q <= c_d;  r0_q <= r0_d;  r1_q <= r1_d;
    c0_q <= c0_d;  c1_q <= c1_d;  i_q <= i_d;  j_q <= j_d;
    ti_q  <= i_q;
    tj_q  <= j_q;
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  carule_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (cell_symbol_i),
    .rdata_o (mem_rdata)
  );

  carule_cond_count #(
    .NUM_RULES  (NUM_RULES),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cctrl),
    .rdata_i (mem_rdata),
    .cur_i   (cur_q),
    .nr_i    (nr),
    .rules_i (rules_q),
    .res_o   (fire_res)
  );

  assign out_valid_o   = out_valid_q;
  assign new_symbol_o  = out_q.sym;
  assign rule_number_o = out_q.num;

`ifndef SYNTHESIS
  a_walk_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == carule_pkg::S_WALK) |-> (i_q <= r1_q) && (j_q <= c1_q))
    else $error("window walk out of bounds");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == carule_pkg::S_IDLE))
    else $error("grid written during evaluation");
  a_rule_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(rule_number_o) <= NUM_RULES))
    else $error("rule number out of range");
`endif

endmodule
